FILE: design/tfn_pkg.sv
// Shared constants for the triangle face normal pipeline.
// Used by triangle_face_normal and by tfn_checker; no dependencies.
package tfn_pkg;

   localparam int NORM_BITS      = 30;
   localparam int NORM_MSB       = NORM_BITS - 1;
   localparam int SQ_WIDTH       = 2 * NORM_BITS;
   localparam int SUM_WIDTH      = SQ_WIDTH + 2;
   localparam int ROOT_WIDTH     = SUM_WIDTH / 2;
   localparam int REM_WIDTH      = ROOT_WIDTH + 3;
   localparam int DREM_WIDTH     = ROOT_WIDTH + 1;
   localparam int NORMAL_WIDTH   = 16;
   localparam int RSP_DATA_WIDTH = 3 * NORMAL_WIDTH;

endpackage

FILE: design/triangle_face_normal.sv
// Triangle face normal: edges, cross product, normalization to unit length.
// Pipelined datapath with output skid register; depends on tfn_pkg.
//
// Usage:
//   req channel carries one triangle per transfer: nine signed corner
//   coordinates a, b, c packed in req_tdata. rsp channel returns one
//   transfer per triangle: the unit normal in Q1.NORMAL_FRAC_BITS form in
//   rsp_tdata and the degenerate flag in rsp_tuser. csr_wr_en/csr_wr_data
//   write flip_winding, which reverses the cross product order.
//   From the input transfer to rsp_tvalid the pipeline has nine arithmetic
//   stages, one square-root stage per root bit (31), one divider setup
//   stage, one divide stage per quotient bit and the output register.
//   Throughput is one triangle per cycle while rsp_tready stays high.
//   When the receiver stalls, the result moves to a skid register and the
//   pipeline holds in the next cycle; req_tready drops until the skid
//   register drains. Nothing is dropped or repeated.
//   Reset clears all valid bits and flip_winding.
module triangle_face_normal
   import tfn_pkg::*;
#(
   parameter int COORD_WIDTH      = 24,
   parameter int NORMAL_FRAC_BITS = 14
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic                      csr_wr_data,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z from bit 0 up, zero pad
   input  logic [((9*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // normal_x, normal_y, normal_z from bit 0 up
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   // degenerate
   output logic                      rsp_tuser
);

   localparam int CW    = COORD_WIDTH;
   localparam int F     = NORMAL_FRAC_BITS;
   localparam int CLIP  = (CW > 30) ? 30 : CW;
   localparam int PRE   = CW - CLIP;
   localparam int EW    = CLIP + 1;
   localparam int PW    = 2 * EW;
   localparam int MW    = 2 * EW;
   localparam int PIW   = $clog2(MW);
   localparam int NW    = NORM_BITS + F + 1;
   localparam int QW    = F + 1;

   logic run;
   logic flip_ff;

   // output and skid
   logic                      out_vld_ff;
   logic [RSP_DATA_WIDTH-1:0] out_data_ff;
   logic                      out_deg_ff;
   logic                      skid_vld_ff;
   logic [RSP_DATA_WIDTH-1:0] skid_data_ff;
   logic                      skid_deg_ff;

   assign run        = !skid_vld_ff;
   assign req_tready = run;

   always_ff @(posedge clock) begin
      if (reset) begin
         flip_ff <= 1'b0;
      end else if (csr_wr_en) begin
         flip_ff <= csr_wr_data;
      end
   end

   // S1: edges
   logic                 s1_vld_ff;
   logic signed [EW-1:0] s1_u_ff [3];
   logic signed [EW-1:0] s1_w_ff [3];
   logic signed [CW-1:0] pt [9];
   logic signed [CW:0]   du [3];
   logic signed [CW:0]   dw [3];
   logic signed [CW:0]   su [3];
   logic signed [CW:0]   sw [3];

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         pt[k] = $signed(req_tdata[k*CW +: CW]);
      end
      for (int i = 0; i < 3; i++) begin
         du[i] = (CW+1)'(pt[3+i]) - (CW+1)'(pt[i]);
         dw[i] = (CW+1)'(pt[6+i]) - (CW+1)'(pt[i]);
         su[i] = du[i] >>> PRE;
         sw[i] = dw[i] >>> PRE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (run) begin
         s1_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (run) begin
         for (int i = 0; i < 3; i++) begin
            s1_u_ff[i] <= su[i][EW-1:0];
            s1_w_ff[i] <= sw[i][EW-1:0];
         end
      end
   end

   // S2: products
   logic                 s2_vld_ff;
   logic signed [PW-1:0] s2_p_ff [6];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (run) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (run) begin
         s2_p_ff[0] <= s1_u_ff[1] * s1_w_ff[2];
         s2_p_ff[1] <= s1_u_ff[2] * s1_w_ff[1];
         s2_p_ff[2] <= s1_u_ff[2] * s1_w_ff[0];
         s2_p_ff[3] <= s1_u_ff[0] * s1_w_ff[2];
         s2_p_ff[4] <= s1_u_ff[0] * s1_w_ff[1];
         s2_p_ff[5] <= s1_u_ff[1] * s1_w_ff[0];
      end
   end

   // S3: cross product
   logic                 s3_vld_ff;
   logic signed [MW:0]   s3_c_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (run) begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (run) begin
         for (int i = 0; i < 3; i++) begin
            s3_c_ff[i] <= (MW+1)'(s2_p_ff[2*i]) - (MW+1)'(s2_p_ff[2*i+1]);
         end
      end
   end

   // S4: magnitude and sign
   logic          s4_vld_ff;
   logic [MW-1:0] s4_mag_ff [3];
   logic [2:0]    s4_neg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (run) begin
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (run) begin
         for (int i = 0; i < 3; i++) begin
            s4_mag_ff[i] <= s3_c_ff[i][MW] ? MW'(-s3_c_ff[i]) : s3_c_ff[i][MW-1:0];
            s4_neg_ff[i] <= s3_c_ff[i][MW] ^ flip_ff;
         end
      end
   end

   // S5: largest magnitude
   logic          s5_vld_ff;
   logic [MW-1:0] s5_mag_ff [3];
   logic [2:0]    s5_neg_ff;
   logic [MW-1:0] s5_max_ff;
   logic [MW-1:0] max01;
   logic [MW-1:0] max_in;

   assign max01  = (s4_mag_ff[0] > s4_mag_ff[1]) ? s4_mag_ff[0] : s4_mag_ff[1];
   assign max_in = (max01 > s4_mag_ff[2]) ? max01 : s4_mag_ff[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else if (run) begin
         s5_vld_ff <= s4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (run) begin
         s5_mag_ff <= s4_mag_ff;
         s5_neg_ff <= s4_neg_ff;
         s5_max_ff <= max_in;
      end
   end

   // S6: leading one position
   logic           s6_vld_ff;
   logic [MW-1:0]  s6_mag_ff [3];
   logic [2:0]     s6_neg_ff;
   logic           s6_deg_ff;
   logic [PIW-1:0] s6_pos_ff;
   logic [PIW-1:0] pos_in;

   always_comb begin
      pos_in = '0;
      for (int b = 0; b < MW; b++) begin
         if (s5_max_ff[b]) begin
            pos_in = PIW'(b);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_vld_ff <= 1'b0;
      end else if (run) begin
         s6_vld_ff <= s5_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (run) begin
         s6_mag_ff <= s5_mag_ff;
         s6_neg_ff <= s5_neg_ff;
         s6_deg_ff <= (s5_max_ff == '0);
         s6_pos_ff <= pos_in;
      end
   end

   // S7: normalize so the largest magnitude has its top bit at NORM_MSB
   logic                 s7_vld_ff;
   logic [NORM_BITS-1:0] s7_mag_ff [3];
   logic [2:0]           s7_neg_ff;
   logic                 s7_deg_ff;
   logic [MW+NORM_MSB-1:0] ext [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ext[i] = {s6_mag_ff[i], {NORM_MSB{1'b0}}} >> s6_pos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_vld_ff <= 1'b0;
      end else if (run) begin
         s7_vld_ff <= s6_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (run) begin
         for (int i = 0; i < 3; i++) begin
            s7_mag_ff[i] <= ext[i][NORM_BITS-1:0];
         end
         s7_neg_ff <= s6_neg_ff;
         s7_deg_ff <= s6_deg_ff;
      end
   end

   // S8: squares
   logic                 s8_vld_ff;
   logic [NORM_BITS-1:0] s8_mag_ff [3];
   logic [2:0]           s8_neg_ff;
   logic                 s8_deg_ff;
   logic [SQ_WIDTH-1:0]  s8_sq_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_vld_ff <= 1'b0;
      end else if (run) begin
         s8_vld_ff <= s7_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (run) begin
         for (int i = 0; i < 3; i++) begin
            s8_sq_ff[i] <= s7_mag_ff[i] * s7_mag_ff[i];
         end
         s8_mag_ff <= s7_mag_ff;
         s8_neg_ff <= s7_neg_ff;
         s8_deg_ff <= s7_deg_ff;
      end
   end

   // S9: sum of squares
   logic                 s9_vld_ff;
   logic [NORM_BITS-1:0] s9_mag_ff [3];
   logic [2:0]           s9_neg_ff;
   logic                 s9_deg_ff;
   logic [SUM_WIDTH-1:0] s9_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s9_vld_ff <= 1'b0;
      end else if (run) begin
         s9_vld_ff <= s8_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (run) begin
         s9_sum_ff <= SUM_WIDTH'(s8_sq_ff[0]) + SUM_WIDTH'(s8_sq_ff[1])
                    + SUM_WIDTH'(s8_sq_ff[2]);
         s9_mag_ff <= s8_mag_ff;
         s9_neg_ff <= s8_neg_ff;
         s9_deg_ff <= s8_deg_ff;
      end
   end

   // square root, one root bit per stage
   logic                  sq_vld_ff  [ROOT_WIDTH];
   logic [REM_WIDTH-1:0]  sq_rem_ff  [ROOT_WIDTH];
   logic [ROOT_WIDTH-1:0] sq_root_ff [ROOT_WIDTH];
   logic [SUM_WIDTH-1:0]  sq_x_ff    [ROOT_WIDTH];
   logic [NORM_BITS-1:0]  sq_mag_ff  [ROOT_WIDTH][3];
   logic [2:0]            sq_neg_ff  [ROOT_WIDTH];
   logic                  sq_deg_ff  [ROOT_WIDTH];

   for (genvar j = 0; j < ROOT_WIDTH; j++) begin : g_sqrt
      logic                  vld_prev;
      logic [REM_WIDTH-1:0]  rem_prev;
      logic [ROOT_WIDTH-1:0] root_prev;
      logic [SUM_WIDTH-1:0]  x_prev;
      logic [NORM_BITS-1:0]  mag_prev [3];
      logic [2:0]            neg_prev;
      logic                  deg_prev;
      logic [REM_WIDTH-1:0]  rem_sh;
      logic [REM_WIDTH-1:0]  trial;
      logic                  ge;

      if (j == 0) begin : g_first
         assign vld_prev  = s9_vld_ff;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign x_prev    = s9_sum_ff;
         assign mag_prev  = s9_mag_ff;
         assign neg_prev  = s9_neg_ff;
         assign deg_prev  = s9_deg_ff;
      end else begin : g_next
         assign vld_prev  = sq_vld_ff[j-1];
         assign rem_prev  = sq_rem_ff[j-1];
         assign root_prev = sq_root_ff[j-1];
         assign x_prev    = sq_x_ff[j-1];
         assign mag_prev  = sq_mag_ff[j-1];
         assign neg_prev  = sq_neg_ff[j-1];
         assign deg_prev  = sq_deg_ff[j-1];
      end

      assign rem_sh = {rem_prev[REM_WIDTH-3:0], x_prev[SUM_WIDTH-1 -: 2]};
      assign trial  = {1'b0, root_prev, 2'b01};
      assign ge     = (rem_sh >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_vld_ff[j] <= 1'b0;
         end else if (run) begin
            sq_vld_ff[j] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (run) begin
            sq_rem_ff[j]  <= ge ? (rem_sh - trial) : rem_sh;
            sq_root_ff[j] <= {root_prev[ROOT_WIDTH-2:0], ge};
            sq_x_ff[j]    <= {x_prev[SUM_WIDTH-3:0], 2'b00};
            sq_mag_ff[j]  <= mag_prev;
            sq_neg_ff[j]  <= neg_prev;
            sq_deg_ff[j]  <= deg_prev;
         end
      end
   end

   // divider setup: numerator = mag * 2^F + L / 2
   localparam int SQL = ROOT_WIDTH - 1;

   logic                  dp_vld_ff;
   logic [ROOT_WIDTH-1:0] dp_len_ff;
   logic [DREM_WIDTH-1:0] dp_r_ff    [3];
   logic [QW-1:0]         dp_nlow_ff [3];
   logic [2:0]            dp_neg_ff;
   logic                  dp_deg_ff;
   logic [NW-1:0]         numer [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         numer[i] = NW'({sq_mag_ff[SQL][i], {F{1'b0}}})
                  + NW'(sq_root_ff[SQL] >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dp_vld_ff <= 1'b0;
      end else if (run) begin
         dp_vld_ff <= sq_vld_ff[SQL];
      end
   end

   always_ff @(posedge clock) begin
      if (run) begin
         for (int i = 0; i < 3; i++) begin
            dp_r_ff[i]    <= DREM_WIDTH'(numer[i][NW-1:QW]);
            dp_nlow_ff[i] <= numer[i][QW-1:0];
         end
         dp_len_ff <= sq_root_ff[SQL];
         dp_neg_ff <= sq_neg_ff[SQL];
         dp_deg_ff <= sq_deg_ff[SQL];
      end
   end

   // restoring divide, one quotient bit per stage, three lanes
   logic                  dv_vld_ff  [QW];
   logic [ROOT_WIDTH-1:0] dv_len_ff  [QW];
   logic [DREM_WIDTH-1:0] dv_r_ff    [QW][3];
   logic [QW-1:0]         dv_nlow_ff [QW][3];
   logic [QW-1:0]         dv_q_ff    [QW][3];
   logic [2:0]            dv_neg_ff  [QW];
   logic                  dv_deg_ff  [QW];

   for (genvar k = 0; k < QW; k++) begin : g_div
      logic                  vld_prev;
      logic [ROOT_WIDTH-1:0] len_prev;
      logic [DREM_WIDTH-1:0] r_prev    [3];
      logic [QW-1:0]         nlow_prev [3];
      logic [QW-1:0]         q_prev    [3];
      logic [2:0]            neg_prev;
      logic                  deg_prev;
      logic [DREM_WIDTH-1:0] rs  [3];
      logic [DREM_WIDTH-1:0] r_in [3];
      logic [2:0]            ge;

      if (k == 0) begin : g_first
         assign vld_prev  = dp_vld_ff;
         assign len_prev  = dp_len_ff;
         assign r_prev    = dp_r_ff;
         assign nlow_prev = dp_nlow_ff;
         assign q_prev    = '{default: '0};
         assign neg_prev  = dp_neg_ff;
         assign deg_prev  = dp_deg_ff;
      end else begin : g_next
         assign vld_prev  = dv_vld_ff[k-1];
         assign len_prev  = dv_len_ff[k-1];
         assign r_prev    = dv_r_ff[k-1];
         assign nlow_prev = dv_nlow_ff[k-1];
         assign q_prev    = dv_q_ff[k-1];
         assign neg_prev  = dv_neg_ff[k-1];
         assign deg_prev  = dv_deg_ff[k-1];
      end

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            rs[i]   = {r_prev[i][DREM_WIDTH-2:0], nlow_prev[i][QW-1]};
            ge[i]   = (rs[i] >= {1'b0, len_prev});
            r_in[i] = ge[i] ? (rs[i] - {1'b0, len_prev}) : rs[i];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[k] <= 1'b0;
         end else if (run) begin
            dv_vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (run) begin
            for (int i = 0; i < 3; i++) begin
               dv_r_ff[k][i]    <= r_in[i];
               dv_nlow_ff[k][i] <= {nlow_prev[i][QW-2:0], 1'b0};
               dv_q_ff[k][i]    <= {q_prev[i][QW-2:0], ge[i]};
            end
            dv_len_ff[k] <= len_prev;
            dv_neg_ff[k] <= neg_prev;
            dv_deg_ff[k] <= deg_prev;
         end
      end
   end

   // output: saturate, sign, zero when degenerate, pack
   localparam int DVL = QW - 1;
   localparam logic [QW-1:0] LIM = QW'(1) << F;

   logic [QW-1:0]             qc      [3];
   logic [31:0]               sval    [3];
   logic [RSP_DATA_WIDTH-1:0] data_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         qc[i]   = (dv_q_ff[DVL][i] > LIM) ? LIM : dv_q_ff[DVL][i];
         sval[i] = dv_neg_ff[DVL][i] ? (32'd0 - 32'(qc[i])) : 32'(qc[i]);
         if (dv_deg_ff[DVL]) begin
            sval[i] = '0;
         end
         data_in[i*NORMAL_WIDTH +: NORMAL_WIDTH] = sval[i][NORMAL_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (run) begin
         out_vld_ff <= dv_vld_ff[DVL];
      end
   end

   always_ff @(posedge clock) begin
      if (run) begin
         out_data_ff <= data_in;
         out_deg_ff  <= dv_deg_ff[DVL];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         skid_vld_ff <= !rsp_tready;
      end else begin
         skid_vld_ff <= out_vld_ff && !rsp_tready;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_vld_ff) begin
         skid_data_ff <= out_data_ff;
         skid_deg_ff  <= out_deg_ff;
      end
   end

   assign rsp_tvalid = skid_vld_ff || out_vld_ff;
   assign rsp_tdata  = skid_vld_ff ? skid_data_ff : out_data_ff;
   assign rsp_tuser  = skid_vld_ff ? skid_deg_ff : out_deg_ff;

endmodule

FILE: design/tfn_checker.sv
// Port-level checks for triangle_face_normal, attached by bind.
// Depends on tfn_pkg.
module tfn_checker
   import tfn_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   input logic                      rsp_tuser
);

   a_rst_idle: assert property (@(posedge clock) $past(reset) && !reset |-> !rsp_tvalid)
      else $error("result valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("degenerate result with nonzero normal");

   a_nondeg_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata != '0)
      else $error("regular result with zero normal");

endmodule

bind triangle_face_normal tfn_checker u_tfn_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

FILE: bench/triangle_face_normal_tb.sv
// Self-checking bench for triangle_face_normal: directed table then random triangles,
// each result checked against a built-in integer predictor. Depends on tfn_pkg.
module triangle_face_normal_tb
   import tfn_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW = 24;
   localparam int FB = 14;
   localparam int REQ_W = ((9*CW+7)/8)*8;
   localparam int LATENCY = 43 + FB;

   typedef struct packed {
      logic [NORMAL_WIDTH-1:0] nx, ny, nz;
      logic                    degen;
   } normal_type;

   typedef struct {
      logic [CW-1:0] crd [9];
      logic          known;
      normal_type    res;
   } tri_row_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_wr_en = 0;
   logic csr_wr_data = 0;
   logic req_tvalid = 0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic rsp_tuser;

   logic flip = 0;
   logic quiet = 0;
   normal_type normals_due [$];
   int errors = 0;
   int n_sent = 0;
   int n_checked = 0;
   int n_degen = 0;

   always #2 clock = ~clock;

   triangle_face_normal u_dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic normal_type face_normal(logic [CW-1:0] crd [9], logic flp);
      longint p [9];
      longint u [3], w [3], c [3];
      longint unsigned mag [3], m, sum, len, q;
      logic neg [3];
      logic [NORMAL_WIDTH-1:0] o [3];
      normal_type r;
      for (int i = 0; i < 9; i++) p[i] = longint'($signed(crd[i]));
      for (int i = 0; i < 3; i++) begin
         u[i] = p[3+i] - p[i];
         w[i] = p[6+i] - p[i];
      end
      c[0] = u[1]*w[2] - u[2]*w[1];
      c[1] = u[2]*w[0] - u[0]*w[2];
      c[2] = u[0]*w[1] - u[1]*w[0];
      m = 0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = (c[i] < 0) != flp;
         mag[i] = c[i] < 0 ? -c[i] : c[i];
         if (mag[i] > m) m = mag[i];
      end
      if (m == 0) begin
         r = '0;
         r.degen = 1;
         return r;
      end
      while (m >= (64'd1 << 30)) begin
         m >>= 1;
         for (int i = 0; i < 3; i++) mag[i] >>= 1;
      end
      while (m < (64'd1 << 29)) begin
         m <<= 1;
         for (int i = 0; i < 3; i++) mag[i] <<= 1;
      end
      sum = mag[0]*mag[0] + mag[1]*mag[1] + mag[2]*mag[2];
      len = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
         q = ((mag[i] << FB) + (len >> 1)) / len;
         if (q > (64'd1 << FB)) q = 64'd1 << FB;
         o[i] = neg[i] ? NORMAL_WIDTH'(-q) : NORMAL_WIDTH'(q);
      end
      r.nx = o[0];
      r.ny = o[1];
      r.nz = o[2];
      r.degen = 0;
      return r;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("ERROR t=%0t result %0d %s: got %0h want %0h", $realtime, n_checked, what,
         got, want);
      errors++;
   endtask

   // response side: random stalls, compare each transfer
   initial begin
      int hold;
      normal_type e;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            if (normals_due.size() == 0) begin
               report("unexpected", rsp_tdata[31:0], 0);
            end else begin
               e = normals_due.pop_front();
               if (rsp_tdata[15:0] != e.nx) report("normal_x", rsp_tdata[15:0], e.nx);
               if (rsp_tdata[31:16] != e.ny) report("normal_y", rsp_tdata[31:16], e.ny);
               if (rsp_tdata[47:32] != e.nz) report("normal_z", rsp_tdata[47:32], e.nz);
               if (rsp_tuser != e.degen) report("degenerate", rsp_tuser, e.degen);
               if (e.degen) n_degen++;
            end
            n_checked++;
         end
         if (hold > 0) begin
            hold--;
            rsp_tready <= 0;
         end else if (!reset && !quiet && $urandom_range(0, 7) == 0) begin
            hold = $urandom_range(1, 13);
            rsp_tready <= 0;
         end else begin
            rsp_tready <= !reset;
         end
      end
   end

   task automatic send(logic [CW-1:0] crd [9], logic known, normal_type want);
      normal_type pred;
      int gap;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 13);
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      pred = face_normal(crd, flip);
      if (known && pred != want) begin
         if (pred.nx != want.nx) report("table normal_x", 32'(pred.nx), 32'(want.nx));
         if (pred.ny != want.ny) report("table normal_y", 32'(pred.ny), 32'(want.ny));
         if (pred.nz != want.nz) report("table normal_z", 32'(pred.nz), 32'(want.nz));
         if (pred.degen != want.degen)
            report("table degenerate", 32'(pred.degen), 32'(want.degen));
      end
      req_tvalid <= 1;
      for (int i = 0; i < 9; i++) req_tdata[i*CW +: CW] <= crd[i];
      do @(posedge clock); while (!req_tready);
      normals_due.push_back(pred);
      n_sent++;
   endtask

   task automatic write_flip(logic v);
      req_tvalid <= 0;
      while (normals_due.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      csr_wr_en <= 1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 0;
      flip = v;
   endtask

   function automatic logic [CW-1:0] rnd_coord(int mode);
      case (mode)
         0: return CW'($urandom);
         1: return CW'($signed($urandom_range(0, 2000)) - 1000);
         2: return $urandom_range(0, 1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
         default: return CW'($signed($urandom_range(0, 65535)) - 32768);
      endcase
   endfunction

   initial begin
      tri_row_type tbl [$];
      tri_row_type row;
      logic [CW-1:0] crd [9];
      logic [CW-1:0] mx, mn, one;
      int mode;
      normal_type z;
      mx = {1'b0, {(CW-1){1'b1}}};
      mn = {1'b1, {(CW-1){1'b0}}};
      one = CW'(32768);
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // degenerate: all corners equal
      z = '0;
      z.degen = 1;
      row.known = 1;
      row.res = z;
      row.crd = '{default: '0};
      tbl.push_back(row);
      row.crd = '{default: mx};
      tbl.push_back(row);
      row.crd = '{default: mn};
      tbl.push_back(row);
      // collinear
      row.crd = '{0, 0, 0, one, one, one, 2*one, 2*one, 2*one};
      tbl.push_back(row);
      // unit triangles on axis planes: +z, +x, +y
      row.res = '{0, 0, 16384, 0};
      row.crd = '{0, 0, 0, one, 0, 0, 0, one, 0};
      tbl.push_back(row);
      row.res = '{16384, 0, 0, 0};
      row.crd = '{0, 0, 0, 0, one, 0, 0, 0, one};
      tbl.push_back(row);
      row.res = '{0, 16384, 0, 0};
      row.crd = '{0, 0, 0, 0, 0, one, one, 0, 0};
      tbl.push_back(row);
      row.known = 0;
      // extreme spans, plus a minimal one
      row.crd = '{mn, mn, mn, mx, mn, mn, mn, mx, mn};
      tbl.push_back(row);
      row.crd = '{mx, mx, mx, mn, mx, mx, mx, mn, mx};
      tbl.push_back(row);
      row.crd = '{mn, mx, mn, mx, mn, mx, mx, mx, mn};
      tbl.push_back(row);
      row.crd = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
      tbl.push_back(row);
      row.crd = '{mx, 0, mn, 0, mx, 0, mn, mn, mx};
      tbl.push_back(row);
      row.crd = '{1, 2, 3, mx, 7, mn, 5, mn, mx};
      tbl.push_back(row);

      for (int f = 0; f < 2; f++) begin
         if (f == 1) write_flip(1);
         foreach (tbl[i]) begin
            row = tbl[i];
            if (f == 1 && row.known && !row.res.degen) begin
               row.res.nx = -row.res.nx;
               row.res.ny = -row.res.ny;
               row.res.nz = -row.res.nz;
            end
            send(row.crd, row.known, row.res);
         end
      end

      for (int k = 0; k < 500; k++) begin
         if (k == 150) write_flip(0);
         if (k == 300) write_flip(1);
         if (k == 420) quiet = 1;
         mode = $urandom_range(0, 3);
         for (int i = 0; i < 9; i++) crd[i] = rnd_coord(mode);
         if ($urandom_range(0, 15) == 0) for (int i = 3; i < 9; i++) crd[i] = crd[i%3];
         send(crd, 0, z);
      end
      req_tvalid <= 0;
      while (normals_due.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      $display("Sent %0d triangles with both winding settings, checked %0d normals", n_sent,
         n_checked);
      $display("%0d degenerate results seen", n_degen);
      if (errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #2ms;
      $display("Mismatches found");
      $finish;
   end

endmodule

FILE: sim.f
design/tfn_pkg.sv
design/triangle_face_normal.sv
design/tfn_checker.sv
bench/triangle_face_normal_tb.sv
